@@ src/autorange_hold_confirm_core_defines.svh @@
// Assertion macros shared by the autorange confirmation core.
`ifndef AUTORANGE_HOLD_CONFIRM_CORE_DEFINES_SVH
`define AUTORANGE_HOLD_CONFIRM_CORE_DEFINES_SVH

// Implication checked in the same cycle, sampled on clk_i and idle during reset.
`define AHC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define AHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ahc_pkg.sv @@
// Types and constants of the autorange confirmation core.
`timescale 1ns / 1ps
package ahc_pkg;

  localparam int unsigned VoltW = 22;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HoldW = 16;
  localparam int unsigned RangeW = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RangeW-1:0] RANGE_HIGH = 2'd0;
  localparam logic [RangeW-1:0] RANGE_MID  = 2'd1;
  localparam logic [RangeW-1:0] RANGE_LOW  = 2'd2;

  localparam logic [TimeW-1:0] HALF_WRAP = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_AUTO_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DOWN_TH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UP_TH      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVER_SET   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OVER_CLEAR = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DOWN_HOLD  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UP_HOLD    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MAX_GAP    = 3'd7;

  typedef struct packed {
    logic             auto_mode;
    logic [VoltW-1:0] down_th;
    logic [VoltW-1:0] up_th;
    logic [VoltW-1:0] over_set;
    logic [VoltW-1:0] over_clear;
    logic [HoldW-1:0] down_hold;
    logic [HoldW-1:0] up_hold;
    logic [HoldW-1:0] max_gap;
  } ahc_cfg_t;

  typedef struct packed {
    logic [VoltW-1:0]  volt;
    logic [TimeW-1:0]  blk_seq;
    logic [TimeW-1:0]  done_ms;
    logic [TimeW-1:0]  now_ms;
    logic [RangeW-1:0] range;
  } ahc_item_t;

  typedef struct packed {
    logic             have_prev;
    logic [TimeW-1:0] prev_seq;
    logic [TimeW-1:0] prev_done;
    logic             up_pending;
    logic             down_pending;
    logic [TimeW-1:0] up_since;
    logic [TimeW-1:0] down_since;
    logic             ovr_state;
  } ahc_state_t;

  typedef struct packed {
    logic              accepted;
    logic              step_request;
    logic [RangeW-1:0] requested_range;
    logic              over_range_flag;
    logic              up_waiting;
    logic              down_waiting;
  } ahc_result_t;

endpackage

@@ src/ahc_cfg_regs.sv @@
// Configuration register file of the autorange confirmation core.
`timescale 1ns / 1ps
module ahc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ahc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ahc_pkg::VoltW-1:0]    cfg_data_i,
  output ahc_pkg::ahc_cfg_t            cfg_o
);
  import ahc_pkg::*;

  ahc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AUTO_MODE:  cfg_d.auto_mode  = cfg_data_i[0];
        REG_DOWN_TH:    cfg_d.down_th    = cfg_data_i;
        REG_UP_TH:      cfg_d.up_th      = cfg_data_i;
        REG_OVER_SET:   cfg_d.over_set   = cfg_data_i;
        REG_OVER_CLEAR: cfg_d.over_clear = cfg_data_i;
        REG_DOWN_HOLD:  cfg_d.down_hold  = cfg_data_i[HoldW-1:0];
        REG_UP_HOLD:    cfg_d.up_hold    = cfg_data_i[HoldW-1:0];
        REG_MAX_GAP:    cfg_d.max_gap    = cfg_data_i[HoldW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_mode  <= 1'b1;
      cfg_q.down_th    <= 22'd3000000;
      cfg_q.up_th      <= 22'd200000;
      cfg_q.over_set   <= 22'd3200000;
      cfg_q.over_clear <= 22'd3000000;
      cfg_q.down_hold  <= 16'd50;
      cfg_q.up_hold    <= 16'd200;
      cfg_q.max_gap    <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/ahc_in_stage.sv @@
// Input register stage: holds one block beat until the decision logic takes it.
`timescale 1ns / 1ps
module ahc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ahc_pkg::ahc_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output ahc_pkg::ahc_item_t item_o
);
  import ahc_pkg::*;

  logic      valid_q, valid_d;
  ahc_item_t item_q;
  logic      take;

  // The stage frees itself in the same cycle that its beat moves on.
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/ahc_decide.sv @@
// Decision logic: staleness and sequence checks, over-range hysteresis and hold timing.
`timescale 1ns / 1ps
module ahc_decide (
  input  ahc_pkg::ahc_cfg_t    cfg_i,
  input  ahc_pkg::ahc_state_t  state_i,
  input  ahc_pkg::ahc_item_t   item_i,
  output ahc_pkg::ahc_state_t  state_o,
  output ahc_pkg::ahc_result_t result_o
);
  import ahc_pkg::*;

  logic [TimeW-1:0] age, adv, spacing, down_since_sel, up_since_sel;
  logic [TimeW-1:0] down_elapsed, up_elapsed;
  logic [TimeW-1:0] max_gap_w;
  logic             stale, seq_bad, gap, is_low, is_high;
  logic             up_keep, down_keep, cond_down, cond_up;
  logic             down_done, up_done;

  always_comb begin
    max_gap_w = {{(TimeW-HoldW){1'b0}}, cfg_i.max_gap};
    age       = item_i.now_ms - item_i.done_ms;
    adv       = item_i.blk_seq - state_i.prev_seq;
    spacing   = item_i.done_ms - state_i.prev_done;

    stale   = age > max_gap_w;
    seq_bad = state_i.have_prev && ((adv == '0) || (adv >= HALF_WRAP));
    gap     = state_i.have_prev &&
              ((adv != {{(TimeW-1){1'b0}}, 1'b1}) || (spacing > max_gap_w));

    // Range code three behaves as the low range.
    is_low  = item_i.range[1];
    is_high = (item_i.range == RANGE_HIGH);

    up_keep   = state_i.up_pending && !gap;
    down_keep = state_i.down_pending && !gap;

    cond_down = (item_i.volt > cfg_i.down_th) && !is_low;
    cond_up   = (item_i.volt < cfg_i.up_th) && !is_high;

    // A fresh confirmation starts its clock at this block's completion time.
    down_since_sel = down_keep ? state_i.down_since : item_i.done_ms;
    up_since_sel   = up_keep ? state_i.up_since : item_i.done_ms;
    down_elapsed   = item_i.done_ms - down_since_sel;
    up_elapsed     = item_i.done_ms - up_since_sel;
    down_done      = down_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg_i.down_hold};
    up_done        = up_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg_i.up_hold};

    state_o  = state_i;
    result_o = '0;

    if (stale) begin
      state_o.up_pending   = 1'b0;
      state_o.down_pending = 1'b0;
    end else if (!seq_bad) begin
      result_o.accepted = 1'b1;
      state_o.have_prev = 1'b1;
      state_o.prev_seq  = item_i.blk_seq;
      state_o.prev_done = item_i.done_ms;

      if (is_low) begin
        if (item_i.volt > cfg_i.over_set) begin
          state_o.ovr_state = 1'b1;
        end else if (item_i.volt < cfg_i.over_clear) begin
          state_o.ovr_state = 1'b0;
        end
      end else begin
        state_o.ovr_state = 1'b0;
      end

      state_o.up_pending   = 1'b0;
      state_o.down_pending = 1'b0;
      if (cfg_i.auto_mode && cond_down) begin
        state_o.down_since = down_since_sel;
        if (down_done) begin
          result_o.step_request    = 1'b1;
          result_o.requested_range = is_high ? RANGE_MID : RANGE_LOW;
        end else begin
          state_o.down_pending = 1'b1;
        end
      end else if (cfg_i.auto_mode && cond_up) begin
        state_o.up_since = up_since_sel;
        if (up_done) begin
          result_o.step_request    = 1'b1;
          result_o.requested_range = is_low ? RANGE_MID : RANGE_HIGH;
        end else begin
          state_o.up_pending = 1'b1;
        end
      end
    end

    result_o.over_range_flag = state_o.ovr_state;
    result_o.up_waiting      = state_o.up_pending;
    result_o.down_waiting    = state_o.down_pending;
  end

endmodule

@@ src/autorange_hold_confirm_core.sv @@
// Top level of the autorange confirmation core: state, result register and checks.
`timescale 1ns / 1ps
`include "autorange_hold_confirm_core_defines.svh"
//
//  Channel   Direction  Handshake               Contents
//  block     in         in_valid_i / in_stall_o  voltage, sequence, times, range
//  result    out        out_valid_o / out_stall_i accept, step, range, flags
//  config    in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// One block beat is taken every cycle while the input is not stalled; it passes through
// the input register and then the result register, from which its result is offered.
// The confirmation state is updated in the same cycle that the result is registered,
// so back-to-back blocks see each other's effect with no bubble.
// Reset clears valid bits, confirmation flags and sets the configuration registers to their defaults.
// A stalled result holds the result register; the input register can still take one beat
// and then stalls too.
module autorange_hold_confirm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ahc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ahc_pkg::VoltW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ahc_pkg::VoltW-1:0]   block_voltage_uv_i,
  input  logic [ahc_pkg::TimeW-1:0]   block_sequence_i,
  input  logic [ahc_pkg::TimeW-1:0]   block_done_ms_i,
  input  logic [ahc_pkg::TimeW-1:0]   now_ms_i,
  input  logic [ahc_pkg::RangeW-1:0]  range_in_use_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        step_request_o,
  output logic [ahc_pkg::RangeW-1:0]  requested_range_o,
  output logic                        over_range_flag_o,
  output logic                        up_waiting_o,
  output logic                        down_waiting_o
);
  import ahc_pkg::*;

  ahc_cfg_t    cfg;
  ahc_item_t   item_in, item_q;
  logic        item_valid, advance;
  ahc_state_t  state_q, state_d;
  ahc_result_t res_d, res_q;
  logic        out_valid_q, out_valid_d;

  assign item_in.volt    = block_voltage_uv_i;
  assign item_in.blk_seq = block_sequence_i;
  assign item_in.done_ms = block_done_ms_i;
  assign item_in.now_ms  = now_ms_i;
  assign item_in.range   = range_in_use_i;

  ahc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ahc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  ahc_decide u_decide (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // A beat moves on when the result register is empty or is being emptied.
  assign advance = item_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = res_q.accepted;
  assign step_request_o    = res_q.step_request;
  assign requested_range_o = res_q.requested_range;
  assign over_range_flag_o = res_q.over_range_flag;
  assign up_waiting_o      = res_q.up_waiting;
  assign down_waiting_o    = res_q.down_waiting;

  `AHC_ASSERT_SAME(a_step_needs_accept, out_valid_o && step_request_o, accepted_o,
                   "step on rejected block")
  `AHC_ASSERT_SAME(a_step_clears_wait, out_valid_o && step_request_o,
                   !up_waiting_o && !down_waiting_o, "pending survives step")
  `AHC_ASSERT_SAME(a_wait_exclusive, out_valid_o, !(up_waiting_o && down_waiting_o),
                   "both confirmations pending")
  `AHC_ASSERT_SAME(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i,
                   "input stalled with room downstream")
  `AHC_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_o, "result beat lost")

endmodule
